/* rtl/core/assert_macros.svh */
// Assertion macros shared by the heart rate block.
// Define NO_ASSERTIONS to compile every macro to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define BIHR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");

// Condition must never be true outside reset.
`define BIHR_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("forbidden condition seen");

`else

`define BIHR_ASSERT(lbl, clk, rst_n, prop)
`define BIHR_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

/* rtl/core/bihr_pkg.sv */
// Package for the beat interval heart rate block: widths, constants and word types.
// Used by bihr_div and beat_interval_heart_rate; depends on nothing.
package bihr_pkg;

	localparam int TIME_W        = 32;
	localparam int BPM_W         = 16;
	localparam int WARMUP_W      = 4;
	localparam int DIVIDEND_W    = 20;
	localparam int HISTORY_DEPTH_DEF = 5;

	localparam logic [BPM_W-1:0]    MS_PER_MINUTE = 16'd60000;
	localparam logic [WARMUP_W-1:0] WARMUP_RESET  = 4'd5;
	localparam logic [WARMUP_W-1:0] TALLY_MAX     = 4'd15;

	// Input word: one sample of the beat line.
	typedef struct packed {
		logic              beat_level;
		logic [TIME_W-1:0] time_ms;
	} in_word_t;

	// Output word: one rate result.
	typedef struct packed {
		logic [BPM_W-1:0] instant_bpm;
		logic [BPM_W-1:0] average_bpm;
	} out_word_t;

	// Request to the shared divider.
	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [TIME_W-1:0]     divisor;
	} div_req_t;

	// Status from the shared divider.
	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [DIVIDEND_W-1:0] quotient;
	} div_rsp_t;

endpackage

/* rtl/core/bihr_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on bihr_pkg for the operand widths and request/status types.
module bihr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bihr_pkg::div_req_t req,
	output bihr_pkg::div_rsp_t rsp
);

	localparam int CNT_W = $clog2(bihr_pkg::DIVIDEND_W);

	logic [bihr_pkg::TIME_W:0]       rem_q;
	logic [bihr_pkg::DIVIDEND_W-1:0] quo_q;
	logic [bihr_pkg::TIME_W-1:0]     dvs_q;
	logic [CNT_W-1:0]                cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [bihr_pkg::TIME_W:0] trial;
	logic [bihr_pkg::TIME_W:0] diff;
	logic                      fits;

	// One shift, compare and subtract step.
	always_comb begin
		trial = {rem_q[bihr_pkg::TIME_W-1:0], quo_q[bihr_pkg::DIVIDEND_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// Control: start loads the operands, then one step per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !req.start && busy_q &&
				(cnt_q == CNT_W'(bihr_pkg::DIVIDEND_W - 1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(bihr_pkg::DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Datapath: remainder, quotient shift register and divisor.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff : trial;
			quo_q <= {quo_q[bihr_pkg::DIVIDEND_W-2:0], fits};
		end
	end

	assign rsp.busy     = busy_q;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

/* rtl/core/beat_interval_heart_rate.sv */
// Heart rate from beat intervals: instant and moving-average rate per beat.
// A word without a new beat leaves the block ready for the next word. A counted beat word
// has its result after two passes (load plus 20 steps each) through the divider.
// The next word waits until the sequencer is idle after a counted beat; a result that
// finds the output register full stalls the input until that register is taken.
// Reset (arst_n low) clears the history, tally, arming and warmup (to 5) at once.
`include "assert_macros.svh"

module beat_interval_heart_rate #(
	parameter int HISTORY_DEPTH = bihr_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  bihr_pkg::in_word_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output bihr_pkg::out_word_t               out_data,
	input  logic                              cfg_wr_en,
	input  logic [bihr_pkg::WARMUP_W-1:0]     cfg_wr_data
);

	localparam int SUM_W  = bihr_pkg::BPM_W + $clog2(HISTORY_DEPTH);
	localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RATE,
		S_AVG,
		S_HOLD
	} state_t;

	state_t                          state_q;
	logic                            prev_level_q;
	logic                            armed_q;
	logic [bihr_pkg::TIME_W-1:0]     last_time_q;
	logic [bihr_pkg::BPM_W-1:0]      hist_q [HISTORY_DEPTH];
	logic [SLOT_W-1:0]               slot_q;
	logic [SUM_W-1:0]                sum_q;
	logic [bihr_pkg::WARMUP_W-1:0]   tally_q;
	logic [bihr_pkg::WARMUP_W-1:0]   warmup_q;
	logic                            emit_q;
	logic [bihr_pkg::BPM_W-1:0]      instant_q;
	logic [bihr_pkg::BPM_W-1:0]      average_q;
	logic                            out_valid_q;
	bihr_pkg::out_word_t             out_data_q;

	logic                            accept;
	logic                            beat;
	logic                            start_rate;
	logic [bihr_pkg::TIME_W-1:0]     interval;
	logic [bihr_pkg::BPM_W-1:0]      instant;
	logic [SUM_W-1:0]                new_sum;
	logic [SLOT_W-1:0]               next_slot;
	logic                            out_free;
	logic                            load_out;
	bihr_pkg::div_req_t              div_req;
	bihr_pkg::div_rsp_t              div_rsp;

	// Edge detect and interval measurement on the incoming word.
	always_comb begin
		accept     = in_valid && in_ready;
		beat       = in_data.beat_level && !prev_level_q;
		start_rate = accept && beat && armed_q;
		interval   = in_data.time_ms - last_time_q;
		if (interval == '0) begin
			interval = bihr_pkg::TIME_W'(1);
		end
	end

	// History update, computed when the rate quotient comes back.
	always_comb begin
		instant   = div_rsp.quotient[bihr_pkg::BPM_W-1:0];
		new_sum   = sum_q - SUM_W'(hist_q[slot_q]) + SUM_W'(instant);
		next_slot = (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
		out_free  = !out_valid_q || out_ready;
		load_out  = ((state_q == S_AVG) && div_rsp.done && emit_q && out_free) ||
			((state_q == S_HOLD) && out_free);
	end

	// Divider requests: rate division on a beat, average division after the update.
	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = bihr_pkg::DIVIDEND_W'(bihr_pkg::MS_PER_MINUTE);
		div_req.divisor  = interval;
		if (start_rate) begin
			div_req.start = 1'b1;
		end else if (state_q == S_RATE && div_rsp.done) begin
			div_req.start    = 1'b1;
			div_req.dividend = bihr_pkg::DIVIDEND_W'(new_sum);
			div_req.divisor  = bihr_pkg::TIME_W'(HISTORY_DEPTH);
		end
	end

	bihr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			prev_level_q <= 1'b0;
			armed_q      <= 1'b0;
			last_time_q  <= '0;
			slot_q       <= '0;
			sum_q        <= '0;
			tally_q      <= '0;
			warmup_q     <= bihr_pkg::WARMUP_RESET;
			emit_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				warmup_q <= cfg_wr_data;
			end
			// The output register fills on a load and empties when taken.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						prev_level_q <= in_data.beat_level;
						if (beat) begin
							armed_q     <= 1'b1;
							last_time_q <= in_data.time_ms;
							if (armed_q) begin
								state_q <= S_RATE;
							end
						end
					end
				end
				S_RATE: begin
					if (div_rsp.done) begin
						hist_q[slot_q] <= instant;
						sum_q          <= new_sum;
						slot_q         <= next_slot;
						emit_q         <= (tally_q > warmup_q);
						if (tally_q < bihr_pkg::TALLY_MAX) begin
							tally_q <= tally_q + bihr_pkg::WARMUP_W'(1);
						end
						state_q <= S_AVG;
					end
				end
				S_AVG: begin
					if (div_rsp.done) begin
						if (!emit_q || out_free) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_HOLD;
						end
					end
				end
				S_HOLD: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_RATE && div_rsp.done) begin
			instant_q <= instant;
		end
		if (state_q == S_AVG && div_rsp.done) begin
			average_q <= div_rsp.quotient[bihr_pkg::BPM_W-1:0];
		end
		if (load_out) begin
			out_data_q.instant_bpm <= instant_q;
			out_data_q.average_bpm <= (state_q == S_HOLD) ? average_q :
				div_rsp.quotient[bihr_pkg::BPM_W-1:0];
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The divider is idle whenever a new word may be taken.
	`BIHR_ASSERT(a_idle_div_free, clk, arst_n, in_ready |-> !div_rsp.busy)
	// A counted beat always starts the divider.
	`BIHR_ASSERT(a_beat_starts_div, clk, arst_n, start_rate |=> div_rsp.busy)
	// The history pointer stays inside the history.
	`BIHR_NEVER(a_slot_range, clk, arst_n, slot_q > SLOT_W'(HISTORY_DEPTH - 1))
	// No quotient arrives while the sequencer waits for input.
	`BIHR_NEVER(a_no_stray_done, clk, arst_n, state_q == S_IDLE && div_rsp.done)

endmodule
